>>> hw/rtl/twtp_pkg.sv
package twtp_pkg;

  // Fixed field widths of the channels
  localparam int InBits  = 16;
  localparam int SumBits = 26;

  // Rows shorter than this hold no water
  localparam int MinRow = 3;

  // Saturation limit of the water sum
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  typedef struct packed {
    logic [InBits-1:0] bar_height;
    logic              last_bar;
  } in_item_t;

  typedef struct packed {
    logic [SumBits-1:0] water_total;
    logic               row_truncated;
  } out_item_t;

  // Walk engine status toward the top level
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SumBits-1:0] water;
  } walk_stat_t;

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_FETCH = 3'b010,
    W_STEP  = 3'b100
  } walk_state_e;

endpackage

>>> hw/rtl/twtp_ram.sv
module twtp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/twtp_walk.sv
module twtp_walk #(
  parameter int ADDR_BITS   = 10,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [ADDR_BITS-1:0]     last_idx_i,
  output logic                     rd_en_o,
  output logic [ADDR_BITS-1:0]     rd_addr_o,
  input  logic [HEIGHT_BITS-1:0]   rd_data_i,
  output twtp_pkg::walk_stat_t     stat_o
);

  // Adder wide enough for sum plus any height difference
  localparam int AddW = ((HEIGHT_BITS > twtp_pkg::SumBits) ? HEIGHT_BITS
                                                            : twtp_pkg::SumBits) + 1;

  twtp_pkg::walk_state_e state_q, state_d;
  logic [ADDR_BITS-1:0]        left_q, left_d, right_q, right_d;
  logic [HEIGHT_BITS-1:0]      lh_q, lh_d, rh_q, rh_d;
  logic [HEIGHT_BITS-1:0]      lpk_q, lpk_d, rpk_q, rpk_d;
  logic [twtp_pkg::SumBits-1:0] sum_q, sum_d;
  logic                        pend_r_q, pend_r_d;
  logic                        init_q, init_d;

  logic [HEIGHT_BITS-1:0] lh_e, rh_e, amount;
  logic                   add_en, done;
  logic [AddW-1:0]        sum_ext;

  // Freshly read bar replaces the side that was fetched
  assign lh_e = pend_r_q ? lh_q : rd_data_i;
  assign rh_e = pend_r_q ? rd_data_i : rh_q;

  assign rd_en_o   = (state_q == twtp_pkg::W_FETCH);
  assign rd_addr_o = pend_r_q ? right_q : left_q;

  // Saturating accumulate
  assign sum_ext = AddW'(sum_q) + AddW'(amount);

  always_comb begin
    state_d  = state_q;
    left_d   = left_q;
    right_d  = right_q;
    lh_d     = lh_q;
    rh_d     = rh_q;
    lpk_d    = lpk_q;
    rpk_d    = rpk_q;
    pend_r_d = pend_r_q;
    init_d   = init_q;
    amount   = '0;
    add_en   = 1'b0;
    done     = 1'b0;
    unique case (state_q)
      twtp_pkg::W_IDLE: begin
        if (go_i) begin
          left_d   = '0;
          right_d  = last_idx_i;
          lpk_d    = '0;
          rpk_d    = '0;
          pend_r_d = 1'b0;
          init_d   = 1'b1;
          state_d  = twtp_pkg::W_FETCH;
        end
      end
      twtp_pkg::W_FETCH: begin
        state_d = twtp_pkg::W_STEP;
      end
      twtp_pkg::W_STEP: begin
        lh_d = lh_e;
        rh_d = rh_e;
        if (init_q) begin
          // left end loaded, now fetch right end
          init_d   = 1'b0;
          pend_r_d = 1'b1;
          state_d  = twtp_pkg::W_FETCH;
        end else begin
          if (lh_e < rh_e) begin
            if (lh_e >= lpk_q) begin
              lpk_d = lh_e;
            end else begin
              amount = lpk_q - lh_e;
              add_en = 1'b1;
            end
            left_d   = left_q + 1'b1;
            pend_r_d = 1'b0;
          end else begin
            if (rh_e >= rpk_q) begin
              rpk_d = rh_e;
            end else begin
              amount = rpk_q - rh_e;
              add_en = 1'b1;
            end
            right_d  = right_q - 1'b1;
            pend_r_d = 1'b1;
          end
          if (left_d < right_d) begin
            state_d = twtp_pkg::W_FETCH;
          end else begin
            done    = 1'b1;
            state_d = twtp_pkg::W_IDLE;
          end
        end
      end
      default: state_d = twtp_pkg::W_IDLE;
    endcase
  end

  always_comb begin
    sum_d = sum_q;
    if (state_q == twtp_pkg::W_IDLE && go_i) begin
      sum_d = '0;
    end else if (add_en) begin
      if (sum_ext > AddW'(twtp_pkg::SumMax)) begin
        sum_d = twtp_pkg::SumMax;
      end else begin
        sum_d = sum_ext[twtp_pkg::SumBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= twtp_pkg::W_IDLE;
      left_q   <= '0;
      right_q  <= '0;
      lpk_q    <= '0;
      rpk_q    <= '0;
      sum_q    <= '0;
      pend_r_q <= 1'b0;
      init_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      left_q   <= left_d;
      right_q  <= right_d;
      lpk_q    <= lpk_d;
      rpk_q    <= rpk_d;
      sum_q    <= sum_d;
      pend_r_q <= pend_r_d;
      init_q   <= init_d;
    end
  end

  // Bar heights held between steps
  always_ff @(posedge clk_i) begin
    lh_q <= lh_d;
    rh_q <= rh_d;
  end

  assign stat_o.busy  = (state_q != twtp_pkg::W_IDLE);
  assign stat_o.done  = done;
  assign stat_o.water = sum_d;

endmodule

>>> hw/rtl/trapped_water_two_pointer.sv
// Trapped rain water, two-pointer walk.
//
// Input channel: an item (bar_height, last_bar) is taken on a rising edge
// with start high and busy low. Bars of a row arrive one per cycle, each
// written into the bar memory in the cycle it is taken; busy stays low.
// The item with last_bar set ends the row. Rows of three or more stored
// bars start the walk: busy goes high, and each walk step is one read of
// the single memory read port followed by one compare and update; the
// left end bar is loaded first, before the first step.
// Shorter rows give a zero result in the cycle after the last bar.
// Result channel: done_o pulses for one cycle with result_o; it is set on
// the same edge at which busy falls. The receiver cannot stall: the result
// is shown exactly once. Bars beyond MAX_BARS are dropped and reported in
// row_truncated. Water sums saturate at 2^26-1.
// Reset clears the row count and walk control; memory content is not
// cleared, since the walk only reads bars written in the current row.
module trapped_water_two_pointer #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  twtp_pkg::in_item_t  item_i,
  output logic                done_o,
  output twtp_pkg::out_item_t result_o
);

  localparam int AddrW   = $clog2(MAX_BARS);
  localparam int CntW    = $clog2(MAX_BARS + 1);
  localparam int UseBits = (HEIGHT_BITS < twtp_pkg::InBits) ? HEIGHT_BITS
                                                            : twtp_pkg::InBits;

  logic [CntW-1:0]        count_q, count_d, count_inc;
  logic                   ovf_q, ovf_d;
  logic                   trunc_q, trunc_d;
  logic                   done_q, done_d;
  twtp_pkg::out_item_t    result_q, result_d;

  logic                   accept, full, of_now, short_row, go;
  logic [HEIGHT_BITS-1:0] height;
  logic [AddrW-1:0]       last_idx;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic [HEIGHT_BITS-1:0] rd_data;
  twtp_pkg::walk_stat_t   stat;

  assign accept    = start && !busy;
  assign full      = (count_q == CntW'(MAX_BARS));
  assign of_now    = ovf_q || full;
  assign height    = HEIGHT_BITS'(item_i.bar_height[UseBits-1:0]);
  assign count_inc = full ? count_q : count_q + 1'b1;
  assign last_idx  = AddrW'(count_inc - 1'b1);
  assign short_row = (count_inc < CntW'(twtp_pkg::MinRow));
  assign go        = accept && item_i.last_bar && !short_row;

  // Bar memory
  twtp_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_BARS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (height),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Two-pointer walk engine
  twtp_walk #(
    .ADDR_BITS   (AddrW),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .last_idx_i (last_idx),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .stat_o     (stat)
  );

  // Row bookkeeping and result register
  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    trunc_d  = trunc_q;
    done_d   = 1'b0;
    result_d = result_q;
    if (accept) begin
      if (item_i.last_bar) begin
        count_d = '0;
        ovf_d   = 1'b0;
        trunc_d = of_now;
        if (short_row) begin
          done_d                 = 1'b1;
          result_d.water_total   = '0;
          result_d.row_truncated = of_now;
        end
      end else begin
        count_d = count_inc;
        ovf_d   = of_now;
      end
    end
    if (stat.done) begin
      done_d                 = 1'b1;
      result_d.water_total   = stat.water;
      result_d.row_truncated = trunc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      trunc_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      trunc_q <= trunc_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy     = stat.busy;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> hw/rtl/twtp_chk.sv
module twtp_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input twtp_pkg::in_item_t  item_i,
  input logic                done_o,
  input twtp_pkg::out_item_t result_o
);

  // Every result follows an accepted last bar or the end of a walk
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || (start && item_i.last_bar)))
    else $error("result without a finished row");

  // A walk starts only on an accepted last bar
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && item_i.last_bar))
    else $error("walk started without a last bar");

  // End of a walk always delivers its result
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without a result");

  // A result not preceded by a walk is a short row
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(busy)) |-> (result_o.water_total == '0))
    else $error("short row gave nonzero water");

endmodule

bind trapped_water_two_pointer twtp_chk u_chk (.*);
